@@ rtl/core/rycc_pkg.sv @@
`default_nettype none

package rycc_pkg;

  // Field and datapath widths
  localparam int PIX_W   = 8;                 // one color component
  localparam int OPND_W  = PIX_W + 1;         // signed operand after chroma offset
  localparam int COEF_W  = 18;                // signed Q2.16 coefficient
  localparam int FRAC_W  = 16;                // fraction bits of the coefficients
  localparam int PROD_W  = OPND_W + COEF_W;   // one product
  localparam int SUM_W   = PROD_W + 2;        // sum of three products
  localparam int MAG_W   = SUM_W - FRAC_W - 2; // rounded magnitude (below 2^11)
  localparam int RND_W   = MAG_W + 1;         // signed rounded value
  localparam int OFS_W   = RND_W + 1;         // rounded value plus chroma offset
  localparam int NCOMP   = 3;                 // components per pixel
  localparam int NSTAGE  = 5;                 // register stages in the datapath

  localparam logic [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);
  localparam logic [PIX_W-1:0]  CHROMA_OFS = PIX_W'(128);
  localparam logic [PIX_W-1:0]  PIX_MAX    = PIX_W'(255);

  // Conversion direction
  typedef enum logic {
    DIR_FWD = 1'b0,   // RGB to YCbCr
    DIR_INV = 1'b1    // YCbCr to RGB
  } dir_e;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [OFS_W-1:0]  ofs_t;
  typedef logic [PIX_W-1:0]         pix_t;

  // BT.601 full-range matrix, rows Y, Cb, Cr
  localparam coef_t FWD_COEF [NCOMP][NCOMP] = '{
    '{ 18'sd19595,   18'sd38470,   18'sd7471  },
    '{ -18'sd11056,  -18'sd21712,  18'sd32768 },
    '{ 18'sd32768,   -18'sd27440,  -18'sd5328 }
  };

  // Inverse matrix, rows R, G, B
  localparam coef_t INV_COEF [NCOMP][NCOMP] = '{
    '{ 18'sd65536,   18'sd0,       18'sd91881  },
    '{ 18'sd65536,   -18'sd22551,  -18'sd46799 },
    '{ 18'sd65536,   18'sd116130,  18'sd0      }
  };

endpackage

`default_nettype wire

@@ rtl/core/rgb_ycbcr_color_converter.sv @@
// RGB <-> YCbCr converter, BT.601 full range, one pixel per word.
//
// Channels: pixels enter on the s_axis group and results leave on the
// m_axis group; a word moves when tvalid and tready are both high. The
// cfg channel writes the direction bit (0 = RGB to YCbCr, 1 = YCbCr to RGB);
// cfg_ready_o is always high. Write it only while the pipeline is empty.
//
// Pipeline: a word accepted on s_axis passes five register stages
// (operand, products, sums, rounding, offset and clamp) before it is
// presented on m_axis. Throughput: one pixel per clock while the receiver
// keeps m_axis_tready high, set by the five-stage pipeline where each
// stage holds one pixel and the three rows are multiplied in parallel.
//
// Reset clears all stage valid bits and sets the direction to RGB to YCbCr.
// When the receiver stalls, the output word holds and each stage keeps
// accepting as long as the stage after it has room, so bubbles are filled
// and s_axis_tready drops only once every stage holds a pixel.
`default_nettype none

module rgb_ycbcr_color_converter
  import rycc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // pixel in
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [3*PIX_W-1:0]   s_axis_tdata,   // comp_a, comp_b, comp_c
  // pixel out
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [3*PIX_W-1:0]        m_axis_tdata,   // out_a, out_b, out_c
  // direction register write
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic                 cfg_data_i
);

  dir_e direction_q;

  logic [NSTAGE-1:0] vld_q;
  logic [NSTAGE-1:0] rdy;
  dir_e              dir_q [NSTAGE];

  opnd_t opnd_d [NCOMP];
  opnd_t opnd_q [NCOMP];
  prod_t prod_d [NCOMP][NCOMP];
  prod_t prod_q [NCOMP][NCOMP];
  sum_t  sum_d  [NCOMP];
  sum_t  sum_q  [NCOMP];
  rnd_t  rnd_d  [NCOMP];
  rnd_t  rnd_q  [NCOMP];
  pix_t  pix_d  [NCOMP];
  pix_t  pix_q  [NCOMP];

  // Direction register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DIR_FWD;
    end else if (cfg_valid_i) begin
      direction_q <= dir_e'(cfg_data_i);
    end
  end

  // Stage ready chain: a stage loads when it is empty or its successor loads
  always_comb begin
    rdy[NSTAGE-1] = m_axis_tready || !vld_q[NSTAGE-1];
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = rdy[k+1] || !vld_q[k];
    end
  end

  assign s_axis_tready = rdy[0];

  // Advance valid bits and direction tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      for (int k = 0; k < NSTAGE; k++) begin
        dir_q[k] <= DIR_FWD;
      end
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
        dir_q[0] <= direction_q;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
          dir_q[k] <= dir_q[k-1];
        end
      end
    end
  end

  // Stage 0: unpack, remove chroma offset in inverse mode
  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      opnd_d[c] = opnd_t'({1'b0, s_axis_tdata[c*PIX_W +: PIX_W]});
      if (direction_q == DIR_INV && c != 0) begin
        opnd_d[c] = opnd_d[c] - opnd_t'({1'b0, CHROMA_OFS});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      opnd_q <= opnd_d;
    end
  end

  // Stage 1: nine products
  always_comb begin
    for (int r = 0; r < NCOMP; r++) begin
      for (int c = 0; c < NCOMP; c++) begin
        if (dir_q[0] == DIR_INV) begin
          prod_d[r][c] = PROD_W'(opnd_q[c]) * PROD_W'(INV_COEF[r][c]);
        end else begin
          prod_d[r][c] = PROD_W'(opnd_q[c]) * PROD_W'(FWD_COEF[r][c]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      prod_q <= prod_d;
    end
  end

  // Stage 2: row sums
  always_comb begin
    for (int r = 0; r < NCOMP; r++) begin
      sum_d[r] = SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      sum_q <= sum_d;
    end
  end

  // Stage 3: round half away from zero at the fraction point
  always_comb begin
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] biased;
    logic [MAG_W-1:0] rmag;
    for (int r = 0; r < NCOMP; r++) begin
      mag    = sum_q[r][SUM_W-1] ? SUM_W'(-sum_q[r]) : SUM_W'(sum_q[r]);
      biased = mag + ROUND_HALF;
      rmag   = biased[FRAC_W +: MAG_W];
      if (sum_q[r][SUM_W-1]) begin
        rnd_d[r] = -rnd_t'({1'b0, rmag});
      end else begin
        rnd_d[r] = rnd_t'({1'b0, rmag});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      rnd_q <= rnd_d;
    end
  end

  // Stage 4: add chroma offset in forward mode, clamp to 0..255
  always_comb begin
    ofs_t val;
    for (int r = 0; r < NCOMP; r++) begin
      val = OFS_W'(rnd_q[r]);
      if (dir_q[3] == DIR_FWD && r != 0) begin
        val = val + ofs_t'({1'b0, CHROMA_OFS});
      end
      if (val[OFS_W-1]) begin
        pix_d[r] = '0;
      end else if (val > ofs_t'({1'b0, PIX_MAX})) begin
        pix_d[r] = PIX_MAX;
      end else begin
        pix_d[r] = val[PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      pix_q <= pix_d;
    end
  end

  // Output word
  assign m_axis_tvalid = vld_q[NSTAGE-1];
  assign m_axis_tdata  = {pix_q[2], pix_q[1], pix_q[0]};

  // An output that is free or being taken leaves every stage ready
  a_ready_when_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled although the output can drain");

  // A pixel in stage 0 moves on when stage 1 loads
  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && rdy[1]) |=> vld_q[1])
    else $error("pixel lost between operand and product stages");

  // A held output stage keeps its direction tag
  a_tag_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSTAGE-1] && !rdy[NSTAGE-1]) |=> $stable(dir_q[NSTAGE-1]))
    else $error("direction tag changed under a stalled output");

  // A write sets the direction register
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> (direction_q == dir_e'($past(cfg_data_i))))
    else $error("direction register missed a write");

endmodule

`default_nettype wire

@@ test/tb_rgb_ycbcr_color_converter.sv @@
`timescale 1ns / 1ps

module tb_rgb_ycbcr_color_converter;
  import rycc_pkg::*;

  // One pixel as it travels in tdata: first component in the low byte
  typedef struct packed {
    pix_t c;
    pix_t b;
    pix_t a;
  } pixel_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [3*PIX_W-1:0]   s_axis_tdata = '0;    // comp_a, comp_b, comp_c
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [3*PIX_W-1:0]   m_axis_tdata;         // out_a, out_b, out_c
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_data_i = 1'b0;

  // Local copy of the direction register and the pixels still in flight
  dir_e   dir_q = DIR_FWD;
  pixel_t pending_pixels[$];
  int     fail_count = 0;
  int     burst_left = 0;
  int     ready_mode = 0;
  int     ready_cyc = 0;

  rgb_ycbcr_color_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Round a Q16 sum half away from zero
  function automatic longint round_q16(input longint s);
    if (s >= 0) return (s + 32768) >>> 16;
    return -(((-s) + 32768) >>> 16);
  endfunction

  function automatic pix_t clamp_pix(input longint v);
    if (v < 0) return '0;
    if (v > 255) return PIX_MAX;
    return pix_t'(v);
  endfunction

  // BT.601 full-range conversion in either direction
  function automatic pixel_t convert_pixel(input dir_e d, input pixel_t p);
    longint x0, x1, x2;
    pixel_t q;
    x0 = longint'(p.a);
    x1 = longint'(p.b);
    x2 = longint'(p.c);
    if (d == DIR_FWD) begin
      q.a = clamp_pix(round_q16(19595 * x0 + 38470 * x1 + 7471 * x2));
      q.b = clamp_pix(round_q16(-11056 * x0 - 21712 * x1 + 32768 * x2) + 128);
      q.c = clamp_pix(round_q16(32768 * x0 - 27440 * x1 - 5328 * x2) + 128);
    end else begin
      x1 = x1 - 128;
      x2 = x2 - 128;
      q.a = clamp_pix(round_q16(65536 * x0 + 91881 * x2));
      q.b = clamp_pix(round_q16(65536 * x0 - 22551 * x1 - 46799 * x2));
      q.c = clamp_pix(round_q16(65536 * x0 + 116130 * x1));
    end
    return q;
  endfunction

  // Send one pixel; bursts of random length with random gaps in between
  task automatic send_pixel(input pix_t a, input pix_t b, input pix_t c);
    int gap;
    pixel_t p;
    p.a = a;
    p.b = b;
    p.c = c;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_pixels.push_back(convert_pixel(dir_q, p));
  endtask

  // Hold the input idle until every pixel in flight has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_direction(input dir_e d);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    dir_q = d;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Compare one output word against the oldest prediction
  task automatic check_word(input pixel_t got);
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      $error("unexpected output word %h", got);
      fail_count++;
    end else begin
      want = pending_pixels.pop_front();
      if (got.a !== want.a) begin
        $error("out_a mismatch: expected %0d, got %0d", want.a, got.a);
        fail_count++;
      end
      if (got.b !== want.b) begin
        $error("out_b mismatch: expected %0d, got %0d", want.b, got.b);
        fail_count++;
      end
      if (got.c !== want.c) begin
        $error("out_c mismatch: expected %0d, got %0d", want.c, got.c);
        fail_count++;
      end
    end
  endtask

  // Check accepted words, then pick the next ready value; the stall mode
  // is redrawn at random as ready_cyc advances
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_word(m_axis_tdata);
    ready_cyc <= ready_cyc + 1;
    if (ready_cyc % 64 == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= $urandom_range(0, 1);
      end
      2: begin
        m_axis_tready <= (ready_cyc % 3 == 0);
      end
      default: begin
        m_axis_tready <= (ready_cyc % 8 >= 6);
      end
    endcase
  end

  // Direction must come out of reset as RGB to YCbCr
  task automatic test_reset_direction();
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
  endtask

  // Corners of the RGB cube and the exact-half chroma sums
  task automatic test_forward_corners();
    set_direction(DIR_FWD);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
  endtask

  // Inverse extremes, where most outputs clamp at one end or the other
  task automatic test_inverse_clamp();
    set_direction(DIR_INV);
    send_pixel(8'd0, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd128, 8'd0, 8'd255);
    send_pixel(8'd128, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd128, 8'd255);
  endtask

  function automatic pix_t pick_component(input bit edgy);
    pix_t corner[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    if (edgy) return corner[$urandom_range(0, 5)];
    return pix_t'($urandom_range(0, 255));
  endfunction

  // Random pixels in phases of random direction, some at the range ends or midpoint
  task automatic test_random_phases(input int total);
    int sent;
    int phase_len;
    bit edgy;
    pix_t g;
    sent = 0;
    while (sent < total) begin
      set_direction(dir_e'($urandom_range(0, 1)));
      phase_len = $urandom_range(40, 160);
      // Trim the last phase to the requested total
      if (phase_len > total - sent) phase_len = total - sent;
      repeat (phase_len) begin
        edgy = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 15) == 0) begin
          g = pick_component(edgy);
          send_pixel(g, g, g);
        end else begin
          send_pixel(pick_component(edgy), pick_component(edgy), pick_component(edgy));
        end
      end
      sent += phase_len;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_direction();
    test_forward_corners();
    test_inverse_clamp();
    set_direction(DIR_FWD);
    test_random_phases(830);
    wait_drained();
    repeat (NSTAGE + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** rgb_ycbcr_color_converter: PASSED **");
    end else begin
      $display("** rgb_ycbcr_color_converter: FAILED **");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("** rgb_ycbcr_color_converter: FAILED **");
    $finish;
  end

endmodule
